>>> rtl/stcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table cursor lookup: shared package
// Default sizes, opcode and status codes, result kinds, and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package stcl_pkg;

  // Default sizes for the top level parameters.
  localparam int TableDepthDef = 64;
  localparam int CoordBitsDef  = 8;

  // Input opcodes (carried on the slave tuser).
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes (carried on the master tuser).
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  // Which result the datapath loads into its output register.
  typedef logic [2:0] res_kind_t;
  localparam res_kind_t RES_APPEND    = 3'd0;
  localparam res_kind_t RES_CLEAR     = 3'd1;
  localparam res_kind_t RES_FULL      = 3'd2;
  localparam res_kind_t RES_ORDER     = 3'd3;
  localparam res_kind_t RES_PEND      = 3'd4;
  localparam res_kind_t RES_PEND_LAST = 3'd5;
  localparam res_kind_t RES_MISS      = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      latch_in;   // capture the accepted item
    logic      clamp;      // pull the cursor back inside the table
    logic      cur_dec;    // cursor minus one
    logic      cur_inc;    // cursor plus one
    logic      rd_en;      // read the table
    logic      rd_prev;    // read at cursor minus one instead of cursor
    logic      append_wr;  // store the item at the end of the table
    logic      clear;      // empty the table
    logic      pend_load;  // hold the entry just read as the pending match
    logic      pend_clear; // drop the pending match
    logic      out_load;   // load the output register
    res_kind_t out_kind;   // what to load
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;            // opcode of the captured item
    logic       cur_zero;      // cursor at the first position
    logic       cur_at_end;    // cursor equals the entry count
    logic       cur_below_end; // cursor below the entry count
    logic       key_gt;        // entry read is above the query
    logic       key_le;        // entry read is at or below the query
    logic       key_eq;        // entry read equals the query
    logic       pend_valid;    // a match waits to be sent
    logic       out_free;      // output register can take an item
    logic       tbl_full;      // no room for another entry
    logic       key_order;     // query key below the last stored key
  } dp_stat_t;

endpackage

>>> rtl/sorted_table_cursor_lookup_unit.sv
`timescale 1ns / 1ps
// An append or clear result is loaded into the output register from the response state,
// once that register is free. A lookup's final result follows its table reads, each a
// registered read and then a compare, and waits while the output is stalled.
// The block takes one item at a time: the next item is taken once the controller is idle,
// while the last result may still wait.
// Reset (rst, synchronous, active high) empties the table and sets the cursor to 0.
// ----------------------------------------------------------------------------
// Sorted table cursor lookup unit
// Keeps entries in ascending key order, appends them, and looks up keys
// with a cursor that starts where the previous lookup ended.
// ----------------------------------------------------------------------------
module sorted_table_cursor_lookup_unit #(
  parameter int TABLE_DEPTH = stcl_pkg::TableDepthDef,
  parameter int COORD_BITS  = stcl_pkg::CoordBitsDef,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int IN_DW      = ((3 * COORD_BITS + 16 + 7) / 8) * 8,
  localparam int OUT_DW     = ((IDX_W + 16 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // key_east, key_north, key_above, entry_tag, zero fill
  input  logic [IN_DW-1:0]  s_axis_tdata,
  // opcode
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // match_index, match_tag, zero fill
  output logic [OUT_DW-1:0] m_axis_tdata,
  // status
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int C = COORD_BITS;

  stcl_pkg::dp_cmd_t  cmd;
  stcl_pkg::dp_stat_t stat;
  logic [IDX_W-1:0]   out_index;
  logic [15:0]        out_tag;

  stcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stcl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_axis_tuser),
    .in_east    (s_axis_tdata[C-1:0]),
    .in_north   (s_axis_tdata[2*C-1:C]),
    .in_above   (s_axis_tdata[3*C-1:2*C]),
    .in_tag     (s_axis_tdata[3*C+15:3*C]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_index  (out_index),
    .out_tag    (out_tag),
    .out_last   (m_axis_tlast)
  );

  // Pack the result fields, index in the low bits.
  assign m_axis_tdata = OUT_DW'({out_tag, out_index});

endmodule

>>> rtl/stcl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table cursor lookup: datapath
// Table memory, entry count, cursor, query registers, pending match and the
// output register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module stcl_datapath #(
  parameter int TABLE_DEPTH = stcl_pkg::TableDepthDef,
  parameter int COORD_BITS  = stcl_pkg::CoordBitsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stcl_pkg::dp_cmd_t              cmd,
  output stcl_pkg::dp_stat_t             stat,
  input  logic [1:0]                     in_op,
  input  logic [COORD_BITS-1:0]          in_east,
  input  logic [COORD_BITS-1:0]          in_north,
  input  logic [COORD_BITS-1:0]          in_above,
  input  logic [15:0]                    in_tag,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [$clog2(TABLE_DEPTH)-1:0] out_index,
  output logic [15:0]                    out_tag,
  output logic                           out_last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = 3 * COORD_BITS;

  // Table storage.
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [15:0]      tag_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_key;
  logic [15:0]      rd_tag;

  // Captured item.
  logic [1:0]       op;
  logic [KEY_W-1:0] query;
  logic [15:0]      tag_in;

  // Table bookkeeping.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] cursor_m1;
  logic [KEY_W-1:0] last_key;
  logic [IDX_W-1:0] rd_addr;

  // Pending match.
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [15:0]      pend_tag;

  assign cursor_m1 = cursor - CNT_W'(1);
  assign rd_addr   = cmd.rd_prev ? cursor_m1[IDX_W-1:0] : cursor[IDX_W-1:0];

  // Capture the item on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op     <= in_op;
      query  <= {in_above, in_north, in_east};
      tag_in <= in_tag;
    end
  end

  // Table memory: one write port at the end of the table, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.append_wr) begin
      key_mem[count[IDX_W-1:0]] <= query;
      tag_mem[count[IDX_W-1:0]] <= tag_in;
    end
    if (cmd.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_tag <= tag_mem[rd_addr];
    end
  end

  // The last stored key, for the order check on appends.
  always_ff @(posedge clk) begin
    if (cmd.append_wr) begin
      last_key <= query;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append_wr) begin
      count <= count + CNT_W'(1);
    end
  end

  // Cursor; it follows an append when it sits at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cmd.clear) begin
      cursor <= '0;
    end else if (cmd.clamp) begin
      if (cursor > count) begin
        cursor <= count;
      end
    end else if (cmd.cur_dec) begin
      cursor <= cursor_m1;
    end else if (cmd.cur_inc) begin
      cursor <= cursor + CNT_W'(1);
    end else if (cmd.append_wr && cursor == count) begin
      cursor <= count + CNT_W'(1);
    end
  end

  // Pending match: the entry just read, held until the next read says
  // whether it is the final result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_valid <= 1'b1;
    end else if (cmd.pend_clear) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_idx <= cursor[IDX_W-1:0];
      pend_tag <= rd_tag;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_kind) inside
        stcl_pkg::RES_APPEND: begin
          out_status <= stcl_pkg::ST_OK;
          out_index  <= count[IDX_W-1:0];
          out_tag    <= tag_in;
          out_last   <= 1'b1;
        end
        stcl_pkg::RES_PEND, stcl_pkg::RES_PEND_LAST: begin
          out_status <= stcl_pkg::ST_OK;
          out_index  <= pend_idx;
          out_tag    <= pend_tag;
          out_last   <= (cmd.out_kind == stcl_pkg::RES_PEND_LAST);
        end
        stcl_pkg::RES_FULL: begin
          out_status <= stcl_pkg::ST_FULL;
          out_index  <= '0;
          out_tag    <= '0;
          out_last   <= 1'b1;
        end
        stcl_pkg::RES_ORDER: begin
          out_status <= stcl_pkg::ST_ORDER;
          out_index  <= '0;
          out_tag    <= '0;
          out_last   <= 1'b1;
        end
        stcl_pkg::RES_MISS: begin
          out_status <= stcl_pkg::ST_MISS;
          out_index  <= '0;
          out_tag    <= '0;
          out_last   <= 1'b1;
        end
        default: begin
          out_status <= stcl_pkg::ST_OK;
          out_index  <= '0;
          out_tag    <= '0;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.op            = op;
    stat.cur_zero      = (cursor == '0);
    stat.cur_at_end    = (cursor == count);
    stat.cur_below_end = (cursor < count);
    stat.key_gt        = (rd_key > query);
    stat.key_le        = (rd_key <= query);
    stat.key_eq        = (rd_key == query);
    stat.pend_valid    = pend_valid;
    stat.out_free      = !out_valid || out_ready;
    stat.tbl_full      = (count >= CNT_W'(TABLE_DEPTH));
    stat.key_order     = (count != '0) && (query < last_key);
  end

endmodule

>>> rtl/stcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table cursor lookup: controller
// State machine that sequences appends, clears and the three cursor walks of
// a lookup; a check state issues each table read, a compare state judges it.
// ----------------------------------------------------------------------------
module stcl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_ready,
  input  stcl_pkg::dp_stat_t stat,
  output stcl_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RESP     = 4'd1;
  localparam logic [3:0] S_BACK_CHK = 4'd2;
  localparam logic [3:0] S_BACK_CMP = 4'd3;
  localparam logic [3:0] S_FWD_CHK  = 4'd4;
  localparam logic [3:0] S_FWD_CMP  = 4'd5;
  localparam logic [3:0] S_COL_CHK  = 4'd6;
  localparam logic [3:0] S_COL_CMP  = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (in_op) inside
            stcl_pkg::OP_APPEND, stcl_pkg::OP_CLEAR: begin
              state_next = S_RESP;
            end
            stcl_pkg::OP_LOOKUP: begin
              cmd.clamp  = 1'b1;
              state_next = S_BACK_CHK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      // Append or clear: one result, state updated as it is loaded.
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
          if (stat.op == stcl_pkg::OP_CLEAR) begin
            cmd.out_kind = stcl_pkg::RES_CLEAR;
            cmd.clear    = 1'b1;
          end else if (stat.tbl_full) begin
            cmd.out_kind = stcl_pkg::RES_FULL;
          end else if (stat.key_order) begin
            cmd.out_kind = stcl_pkg::RES_ORDER;
          end else begin
            cmd.out_kind  = stcl_pkg::RES_APPEND;
            cmd.append_wr = 1'b1;
          end
        end
      end
      // Walk back while at the end or the entry is above the query.
      S_BACK_CHK: begin
        if (stat.cur_zero) begin
          state_next = S_FWD_CHK;
        end else if (stat.cur_at_end) begin
          cmd.cur_dec = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_BACK_CMP;
        end
      end
      S_BACK_CMP: begin
        if (stat.key_gt) begin
          cmd.cur_dec = 1'b1;
          state_next  = S_BACK_CHK;
        end else begin
          state_next = S_FWD_CHK;
        end
      end
      // Walk forward past entries at or below the query.
      S_FWD_CHK: begin
        if (stat.cur_below_end) begin
          cmd.rd_en  = 1'b1;
          state_next = S_FWD_CMP;
        end else begin
          state_next = S_COL_CHK;
        end
      end
      S_FWD_CMP: begin
        if (stat.key_le) begin
          cmd.cur_inc = 1'b1;
          state_next  = S_FWD_CHK;
        end else begin
          state_next = S_COL_CHK;
        end
      end
      // Step back over equal entries, sending the previous match each time one is pending.
      S_COL_CHK: begin
        if (stat.cur_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          cmd.cur_dec = 1'b1;
          state_next  = S_COL_CMP;
        end
      end
      S_COL_CMP: begin
        if (!stat.key_eq) begin
          state_next = S_FINISH;
        end else if (!stat.pend_valid) begin
          cmd.pend_load = 1'b1;
          state_next    = S_COL_CHK;
        end else if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = stcl_pkg::RES_PEND;
          cmd.pend_load = 1'b1;
          state_next    = S_COL_CHK;
        end
      end
      // Send the final match, or a miss.
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = stat.pend_valid ? stcl_pkg::RES_PEND_LAST : stcl_pkg::RES_MISS;
          cmd.pend_clear = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/stcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table cursor lookup: port checker
// Watches the top level ports and flags results or handshakes that the
// block must never show.
// ----------------------------------------------------------------------------
module stcl_checker #(
  parameter int OUT_DW = 24
) (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [1:0]        s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata,
  input logic [1:0]        m_axis_tuser,
  input logic              m_axis_tlast
);

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Any status other than ok ends the item's results.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != stcl_pkg::ST_OK |-> m_axis_tlast)
    else $error("error or miss result not marked last");

  // Error and miss results carry no entry.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != stcl_pkg::ST_OK |-> m_axis_tdata == '0)
    else $error("error or miss result carries data");

  // Any item with a real opcode keeps the block busy for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != stcl_pkg::OP_NONE |=> !s_axis_tready)
    else $error("new item taken while the previous one is in progress");

endmodule

bind sorted_table_cursor_lookup_unit stcl_checker #(
  .OUT_DW (OUT_DW)
) u_stcl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/stcl_result_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table lookup result monitor
// Watches both streams of the lookup unit and keeps its own copy of the
// table, the entry count and the cursor. It works out the results of every
// accepted item and compares each item that leaves the block, field by field,
// with the oldest result still due.
// ----------------------------------------------------------------------------
module stcl_result_monitor
  import stcl_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // key_east, key_north, key_above, entry_tag
  input  logic [39:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // match_index, match_tag, zero fill
  input  logic [23:0] m_axis_tdata,
  // status
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count
);

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  index;
    logic [15:0] tag;
    logic        last;
  } lookup_result_t;

  lookup_result_t results_due[$];

  // Mirror of the table contents and of the search cursor.
  logic [23:0] key_mem [DEPTH];
  logic [15:0] tag_mem [DEPTH];
  int entry_total = 0;
  int cursor_pos  = 0;
  int errors      = 0;
  int compared    = 0;

  function automatic lookup_result_t make_result(input logic [1:0] status, input int idx,
                                                 input logic [15:0] tag, input logic last);
    lookup_result_t r;
    r.status = status;
    r.index  = idx[5:0];
    r.tag    = tag;
    r.last   = last;
    return r;
  endfunction

  // Adds a result at the tail of the list of results still due.
  function automatic void queue_due(input lookup_result_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  // Applies one accepted item to the mirror and queues the results it owes.
  task automatic predict_table_op(input logic [1:0] op, input logic [23:0] q,
                                  input logic [15:0] tag);
    lookup_result_t held;
    int hits;
    hits = 0;
    case (op)
      OP_APPEND: begin
        if (entry_total >= DEPTH) begin
          queue_due(make_result(ST_FULL, 0, 16'h0, 1'b1));
        end else if (entry_total > 0 && q < key_mem[entry_total-1]) begin
          queue_due(make_result(ST_ORDER, 0, 16'h0, 1'b1));
        end else begin
          key_mem[entry_total] = q;
          tag_mem[entry_total] = tag;
          // A cursor parked at the end stays at the end.
          if (cursor_pos == entry_total) cursor_pos = entry_total + 1;
          queue_due(make_result(ST_OK, entry_total, tag, 1'b1));
          entry_total++;
        end
      end
      OP_CLEAR: begin
        entry_total = 0;
        cursor_pos  = 0;
        queue_due(make_result(ST_OK, 0, 16'h0, 1'b1));
      end
      OP_LOOKUP: begin
        if (cursor_pos > entry_total) cursor_pos = entry_total;
        // Back off while at the end or sitting on a larger key.
        while (cursor_pos != 0 && (cursor_pos == entry_total || key_mem[cursor_pos] > q))
          cursor_pos--;
        // Step past every key at or below the query.
        while (cursor_pos < entry_total && key_mem[cursor_pos] <= q) cursor_pos++;
        // Walk back over the equal keys; the final one carries last.
        while (cursor_pos != 0 && hits < DEPTH) begin
          cursor_pos--;
          if (key_mem[cursor_pos] != q) break;
          if (hits > 0) queue_due(held);
          held = make_result(ST_OK, cursor_pos, tag_mem[cursor_pos], 1'b0);
          hits++;
        end
        if (hits == 0) begin
          queue_due(make_result(ST_MISS, 0, 16'h0, 1'b1));
        end else begin
          held.last = 1'b1;
          queue_due(held);
        end
      end
      default: begin
        // The unused opcode leaves everything alone.
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Output items are checked before the input item of the same edge is applied;
  // an item accepted now cannot have a result leaving in the same cycle.
  always @(posedge clk) begin : watch
    lookup_result_t seen;
    lookup_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status = m_axis_tuser;
        seen.index  = m_axis_tdata[5:0];
        seen.tag    = m_axis_tdata[21:6];
        seen.last   = m_axis_tlast;
        if (results_due.size() == 0) begin
          $error("unexpected result: status %0d index %0d tag 0x%0h last %0d",
                 seen.status, seen.index, seen.tag, seen.last);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, seen.status);
          check_field("match_index", want.index, seen.index);
          check_field("match_tag", want.tag, seen.tag);
          check_field("last", want.last, seen.last);
          compared++;
        end
      end
      // The key packs as one number: above, north, east from high to low.
      if (s_axis_tvalid && s_axis_tready)
        predict_table_op(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[39:24]);
    end
    fail_count    = errors;
    pending_count = results_due.size();
    checked_count = compared;
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table cursor lookup testbench
// Drives appends, clears and lookups into the lookup unit with random gaps on
// both streams. A short directed opening covers the key extremes, equal keys,
// misses and rejected appends; a table of all-equal keys and random phases
// then build sorted tables, including a full one, and search them so the
// cursor walks both ways. A result monitor predicts and checks every item.
// ----------------------------------------------------------------------------
module testbench;
  import stcl_pkg::*;

  localparam int DEPTH          = TableDepthDef;
  localparam int KEY_MAX        = 32'h00FF_FFFF;
  localparam int ITEM_TARGET    = 330;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_valid;
  logic        s_ready;
  logic [39:0] s_data;
  logic [1:0]  s_user;
  logic        m_valid;
  logic        m_ready;
  logic [23:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  int fail_count;
  int pending_count;
  int checked_count;

  // Stimulus bookkeeping: the keys the table should hold, for picking hits.
  logic [23:0] table_keys[$];
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  int items_sent   = 0;
  int appends_sent = 0;
  int clears_sent  = 0;
  int lookups_sent = 0;
  int ignored_sent = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  sorted_table_cursor_lookup_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  stcl_result_monitor #(.DEPTH(DEPTH)) monitor (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Offers one item after a random gap and returns at the falling edge after
  // it was taken.
  task automatic send_item(input logic [1:0] op, input logic [23:0] key,
                           input logic [15:0] tag);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {tag, key};
    s_user  <= op;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
    case (op)
      OP_APPEND: appends_sent++;
      OP_CLEAR:  clears_sent++;
      OP_LOOKUP: lookups_sent++;
      default:   ignored_sent++;
    endcase
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic append_entry(input logic [23:0] key, input logic [15:0] tag);
    send_item(OP_APPEND, key, tag);
    if (table_keys.size() < DEPTH &&
        (table_keys.size() == 0 || key >= table_keys[table_keys.size()-1]))
      table_keys.insert(table_keys.size(), key);
  endtask

  task automatic clear_table();
    send_item(OP_CLEAR, 24'($urandom), 16'($urandom));
    table_keys.delete();
  endtask

  task automatic lookup(input logic [23:0] key);
    send_item(OP_LOOKUP, key, 16'($urandom));
  endtask

  // Mostly stored keys, some neighbors of stored keys, some fully random.
  function automatic logic [23:0] pick_lookup_key();
    int sel;
    logic [23:0] k;
    sel = $urandom_range(0, 9);
    if (table_keys.size() == 0 || sel < 2) return 24'($urandom_range(0, KEY_MAX));
    k = table_keys[$urandom_range(0, table_keys.size() - 1)];
    if (sel == 2) return k + 24'd1;
    if (sel == 3) return k - 24'd1;
    return k;
  endfunction

  // Appends n ascending keys spread over the whole key range, with repeats,
  // a few rejected out-of-order appends, stray lookups and ignored opcodes.
  task automatic fill_sorted(input int n);
    int span;
    int i;
    logic [23:0] key;
    span = KEY_MAX / (n + 1);
    key  = 24'($urandom_range(0, span));
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 3) != 0) key = key + 24'($urandom_range(1, span));
      append_entry(key, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 19) == 0 && key != 0)
        append_entry(key - 24'($urandom_range(1, key)), 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 29) == 0) send_item(OP_NONE, 24'($urandom), 16'($urandom));
      if ($urandom_range(0, 14) == 0) lookup(pick_lookup_key());
    end
  endtask

  task automatic run_phase(input int n, input int searches);
    int i;
    idle_on = ($urandom_range(0, 3) != 0);
    clear_table();
    fill_sorted(n);
    for (i = 0; i < searches; i++) begin
      lookup(pick_lookup_key());
      // Now and then grow the table between searches.
      if ($urandom_range(0, 7) == 0 && table_keys.size() > 0)
        append_entry(table_keys[table_keys.size()-1] + 24'($urandom_range(0, 3)),
                     16'($urandom_range(0, 65535)));
    end
  endtask

  // Receiver: random stalls per item, plus one long hold on request.
  initial begin : receiver
    int stall;
    m_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [23:0] same_key;
    rst     = 1'b1;
    s_valid = 1'b0;
    s_data  = '0;
    s_user  = OP_APPEND;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: empty table, key extremes, equal keys, rejected appends.
    lookup(24'h123456);
    send_item(OP_NONE, 24'hFFFFFF, 16'hFFFF);
    append_entry(24'h000000, 16'h0000);
    append_entry(24'h000000, 16'hFFFF);
    append_entry(24'h5A5A5A, 16'h1234);
    append_entry(24'h5A5A59, 16'h4321);
    append_entry(24'h800000, 16'hA5A5);
    append_entry(24'hFFFFFF, 16'h5A5A);
    append_entry(24'hFFFFFF, 16'hFFFF);
    lookup(24'hFFFFFF);
    lookup(24'h000000);
    lookup(24'h5A5A5A);
    lookup(24'h5A5A5B);
    lookup(24'h7FFFFF);
    lookup(24'h800000);
    send_item(OP_NONE, 24'h000000, 16'h0000);
    clear_table();
    lookup(24'h000000);
    append_entry(24'hAAAAAA, 16'h00FF);
    lookup(24'hFFFFFF);
    append_entry(24'h555555, 16'hFF00);

    // A table of one repeated key, overfilled while the receiver holds off so
    // the block backs up into its input, then searched.
    idle_on  = 1'b1;
    same_key = 24'($urandom_range(0, KEY_MAX));
    clear_table();
    hold_request = 1'b1;
    repeat (DEPTH + 2) append_entry(same_key, 16'($urandom_range(0, 65535)));
    lookup(same_key);
    lookup(same_key + 24'd1);
    lookup(same_key);

    // A full table of spread keys, then searches across it.
    run_phase(DEPTH + 3, 20);

    // Random phases, mostly small tables.
    while (items_sent < ITEM_TARGET) run_phase($urandom_range(1, 20), $urandom_range(4, 14));

    s_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (32) @(negedge clk);

    $display("Sent %0d appends, %0d clears, %0d lookups and %0d unused opcodes.",
             appends_sent, clears_sent, lookups_sent, ignored_sent);
    $display("Checked %0d results, including full and all-equal tables.", checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
